[rtl/rdz_pkg.sv]
// ============================================================================
// rdz_pkg
// Shared types, result kind codes and zigzag helpers for the delta coder.
// ============================================================================
`default_nettype none

package rdz_pkg;

   localparam int SAMPLE_W = 32;
   localparam int LEN_W    = 11;
   localparam int CWIDTH_W = 6;

   localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

   localparam logic [1:0] KIND_FIXED = 2'd0;
   localparam logic [1:0] KIND_REF   = 2'd1;
   localparam logic [1:0] KIND_CODED = 2'd2;

   // request leaving the front stage, one per accepted sample
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                first;
      logic                have_ref;
      logic                last;
      logic [1:0]          kind;
      logic [SAMPLE_W-1:0] head;
      logic [SAMPLE_W-1:0] delta_max;
   } s0_item_type;

   function automatic logic [SAMPLE_W-1:0] zigzag(input logic [SAMPLE_W-1:0] d);
      return {d[SAMPLE_W-2:0], 1'b0} ^ {SAMPLE_W{d[SAMPLE_W-1]}};
   endfunction

   // bits needed for v, never below 1
   function automatic logic [CWIDTH_W-1:0] width_of(input logic [SAMPLE_W-1:0] v);
      logic [CWIDTH_W-1:0] n;
      n = CWIDTH_W'(1);
      for (int i = 1; i < SAMPLE_W; i++) begin
         if (v[i]) begin
            n = CWIDTH_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[rtl/rdz_ram.sv]
// ============================================================================
// rdz_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ============================================================================
`default_nettype none

module rdz_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/rdz_front.sv]
// ============================================================================
// rdz_front
// Per-sample series tracking: position, constancy, delta maximum, reference
// bank selection and store addressing.
// ============================================================================
`default_nettype none

module rdz_front #(
   parameter int MAX_SERIES_LEN = 1024
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       accept,
   input  wire logic [rdz_pkg::SAMPLE_W-1:0]               sample,
   input  wire logic                                       quadrant_start,
   input  wire logic [rdz_pkg::LEN_W-1:0]                  series_length,
   output logic      [$clog2(MAX_SERIES_LEN):0]            wr_addr,
   output logic      [$clog2(MAX_SERIES_LEN):0]            rd_addr,
   output rdz_pkg::s0_item_type                            item
);

   import rdz_pkg::*;

   localparam int IDX_W = $clog2(MAX_SERIES_LEN);
   localparam int CW    = (IDX_W + 2 > LEN_W) ? IDX_W + 2 : LEN_W;

   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                ref_bank_ff, ref_bank_in;
   logic                have_ref_ff, have_ref_in;
   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [SAMPLE_W-1:0] first_ff, first_in;
   logic                const_ff, const_in;
   logic [SAMPLE_W-1:0] dmax_ff, dmax_in;

   logic                is_first;
   logic                have_ref_eff;
   logic [SAMPLE_W-1:0] dcode;
   logic [CW-1:0]       len_ext, eff_len, idx_next;
   logic                last;

   always_comb begin
      is_first     = (idx_ff == '0);
      have_ref_eff = have_ref_ff & ~(is_first & quadrant_start);
      dcode        = zigzag(sample - prev_ff);

      len_ext = CW'(series_length);
      if (len_ext == '0) begin
         eff_len = CW'(1);
      end else if (len_ext > CW'(MAX_SERIES_LEN)) begin
         eff_len = CW'(MAX_SERIES_LEN);
      end else begin
         eff_len = len_ext;
      end
      idx_next = CW'(idx_ff) + CW'(1);
      last     = (idx_next >= eff_len);

      first_in = is_first ? sample : first_ff;
      const_in = is_first ? 1'b1 : (const_ff & (sample == prev_ff));
      if (is_first) begin
         dmax_in = '0;
      end else begin
         dmax_in = (dcode > dmax_ff) ? dcode : dmax_ff;
      end
      prev_in = sample;

      item.sample    = sample;
      item.first     = is_first;
      item.have_ref  = have_ref_eff;
      item.last      = last;
      item.head      = first_in;
      item.delta_max = dmax_in;
      priority if (const_in) begin
         item.kind = KIND_FIXED;
      end else if (!have_ref_eff) begin
         item.kind = KIND_REF;
      end else begin
         item.kind = KIND_CODED;
      end

      ref_bank_in = ref_bank_ff;
      have_ref_in = have_ref_eff;
      if (last) begin
         idx_in = '0;
         if (item.kind == KIND_REF) begin
            ref_bank_in = ~ref_bank_ff;
            have_ref_in = 1'b1;
         end
      end else begin
         idx_in = idx_next[IDX_W-1:0];
      end
   end

   // current series goes to the bank that is not the reference
   assign wr_addr = {~ref_bank_ff, idx_ff};
   assign rd_addr = { ref_bank_ff, idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         ref_bank_ff <= 1'b0;
         have_ref_ff <= 1'b0;
         prev_ff     <= '0;
         first_ff    <= '0;
         const_ff    <= 1'b1;
         dmax_ff     <= '0;
      end else if (accept) begin
         idx_ff      <= idx_in;
         ref_bank_ff <= ref_bank_in;
         have_ref_ff <= have_ref_in;
         prev_ff     <= prev_in;
         first_ff    <= first_in;
         const_ff    <= const_in;
         dmax_ff     <= dmax_in;
      end
   end

   a_ref_taken: assert property (@(posedge clock) disable iff (reset)
      accept && item.last && item.kind == KIND_REF |=> have_ref_ff && idx_ff == '0)
      else $error("new reference series not recorded");

   a_idx_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !item.last |=> idx_ff != '0)
      else $error("sample position failed to advance");

endmodule

`default_nettype wire

[rtl/rdz_back.sv]
// ============================================================================
// rdz_back
// Reference compare stage and result register: takes the store read data,
// keeps the running reference-code maximum and emits one result per series.
// ============================================================================
`default_nettype none

module rdz_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire rdz_pkg::s0_item_type                in_item,
   input  wire logic [rdz_pkg::SAMPLE_W-1:0]        rd_data,
   output logic                                     in_ready,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [1:0]                          rsp_series_kind,
   output logic signed [rdz_pkg::SAMPLE_W-1:0]      rsp_head_value,
   output logic      [rdz_pkg::CWIDTH_W-1:0]        rsp_code_width
);

   import rdz_pkg::*;

   s0_item_type         s1_ff;
   logic                s1_valid_ff;
   logic [SAMPLE_W-1:0] rmax_ff, rmax_in;
   logic                out_valid_ff;
   logic [1:0]          out_kind_ff;
   logic [SAMPLE_W-1:0] out_head_ff, out_code_ff;

   logic                s1_move;
   logic                load_out;
   logic [SAMPLE_W-1:0] rcode, rbase;

   always_comb begin
      // only a series end needs the result register
      s1_move  = !s1_valid_ff || !s1_ff.last || !out_valid_ff || rsp_ready;
      load_out = s1_valid_ff && s1_ff.last && s1_move;

      rcode = zigzag(rd_data - s1_ff.sample);
      rbase = s1_ff.first ? '0 : rmax_ff;
      if (s1_ff.have_ref && rcode > rbase) begin
         rmax_in = rcode;
      end else begin
         rmax_in = rbase;
      end
   end

   assign in_ready = s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_move) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && in_valid) begin
         s1_ff <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rmax_ff <= '0;
      end else if (s1_valid_ff && s1_move) begin
         rmax_ff <= rmax_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_kind_ff <= s1_ff.kind;
         unique case (s1_ff.kind)
            KIND_FIXED: begin
               out_head_ff <= s1_ff.head;
               out_code_ff <= '0;
            end
            KIND_REF: begin
               out_head_ff <= s1_ff.head;
               out_code_ff <= s1_ff.delta_max;
            end
            default: begin
               out_head_ff <= '0;
               out_code_ff <= rmax_in;
            end
         endcase
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_series_kind = out_kind_ff;
   assign rsp_head_value  = out_head_ff;
   assign rsp_code_width  = (out_kind_ff == KIND_FIXED) ? '0 : width_of(out_code_ff);

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.last && s1_move |=> out_valid_ff)
      else $error("series end produced no result");

   a_coded_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_series_kind == KIND_CODED |-> rsp_head_value == '0)
      else $error("coded series carries a head value");

endmodule

`default_nettype wire

[rtl/reference_delta_zigzag_series_coder.sv]
// ============================================================================
// reference_delta_zigzag_series_coder
// Streaming zigzag delta coder for fixed-length series grouped in quadrants.
// ============================================================================
// Usage:
//   req_*  : one sample per request, with req_quadrant_start on the first
//            sample of the first series of a quadrant (looked at only there).
//   rsp_*  : one result at the end of each series: fixed value, new
//            reference (first sample and delta code width), or width of the
//            codes against the reference.
//   csr_*  : series length, always ready; write only while the block is idle.
// Path: last request -> compare stage register -> result register.
// Throughput: one request per cycle while req_ready is high; each sample does
//   one store write and one reference read on the two ports of the series store.
// Reset: length returns to 1024, no reference; store not cleared. User must
//   have a reference entry written before it is read; block won't enforce it.
// Stall: the result register holds while rsp_ready is low; requests still
//   flow until a second series end reaches the compare stage behind it.
// ============================================================================
`default_nettype none

module reference_delta_zigzag_series_coder #(
   parameter int MAX_SERIES_LEN = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [rdz_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                req_quadrant_start,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [1:0]                          rsp_series_kind,
   output logic signed [rdz_pkg::SAMPLE_W-1:0]      rsp_head_value,
   output logic      [rdz_pkg::CWIDTH_W-1:0]        rsp_code_width,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rdz_pkg::LEN_W-1:0]           csr_series_length
);

   import rdz_pkg::*;

   localparam int ADDR_W = $clog2(MAX_SERIES_LEN) + 1;
   localparam int DEPTH  = 1 << ADDR_W;

   logic [LEN_W-1:0]    len_ff;
   logic                accept;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   s0_item_type         item;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else if (csr_valid) begin
         len_ff <= csr_series_length;
      end
   end

   rdz_front #(
      .MAX_SERIES_LEN(MAX_SERIES_LEN)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .sample         (req_sample),
      .quadrant_start (req_quadrant_start),
      .series_length  (len_ff),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr),
      .item           (item)
   );

   rdz_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rdz_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .in_item         (item),
      .rd_data         (rd_data),
      .in_ready        (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_series_kind (rsp_series_kind),
      .rsp_head_value  (rsp_head_value),
      .rsp_code_width  (rsp_code_width)
   );

endmodule

`default_nettype wire

[test/reference_delta_zigzag_series_coder_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// reference_delta_zigzag_series_coder_checker
// Watches the request, response and csr channels of the series coder,
// predicts the result of every series and compares each response with it.
// ============================================================================

module reference_delta_zigzag_series_coder_checker #(
   parameter int SERIES_MAX = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [rdz_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                              req_quadrant_start,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [1:0]                        rsp_series_kind,
   input  logic [rdz_pkg::SAMPLE_W-1:0]      rsp_head_value,
   input  logic [rdz_pkg::CWIDTH_W-1:0]      rsp_code_width,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [rdz_pkg::LEN_W-1:0]         csr_series_length,
   output int                                fail_count,
   output int                                pending_results
);
   import rdz_pkg::*;

   typedef struct packed {
      logic [1:0]          kind;
      logic [SAMPLE_W-1:0] head;
      logic [CWIDTH_W-1:0] width;
   } series_result_type;

   // two banks: the reference series and the one streaming in
   logic [SAMPLE_W-1:0] history [2*SERIES_MAX];
   logic [LEN_W-1:0]    length_reg;
   logic                ref_bank;
   logic                ref_present;
   logic                flat;
   int                  pos;
   logic [SAMPLE_W-1:0] prev_value;
   logic [SAMPLE_W-1:0] head_value;
   logic [SAMPLE_W-1:0] step_code_max;
   logic [SAMPLE_W-1:0] ref_code_max;
   series_result_type   series_results [$];
   int                  mismatches = 0;

   function automatic logic [SAMPLE_W-1:0] zigzag_of(input logic [SAMPLE_W-1:0] d);
      logic [SAMPLE_W-1:0] fold;
      fold = d[SAMPLE_W-1] ? '1 : '0;
      return (d << 1) ^ fold;
   endfunction

   function automatic logic [CWIDTH_W-1:0] bits_needed(input logic [SAMPLE_W-1:0] v);
      logic [CWIDTH_W-1:0] n;
      n = CWIDTH_W'(1);
      for (int b = 0; b < SAMPLE_W; b++) begin
         if (v[b]) begin
            n = CWIDTH_W'(b + 1);
         end
      end
      return n;
   endfunction

   function automatic int active_length(input logic [LEN_W-1:0] len);
      if (len == 0) begin
         return 1;
      end
      if (int'(len) > SERIES_MAX) begin
         return SERIES_MAX;
      end
      return int'(len);
   endfunction

   task code_sample(input logic [SAMPLE_W-1:0] x, input logic quad);
      int                  len;
      int                  idx;
      logic                fill_bank;
      logic [SAMPLE_W-1:0] code;
      series_result_type   r;
      len = active_length(length_reg);
      idx = (pos >= SERIES_MAX) ? SERIES_MAX - 1 : pos;
      fill_bank = ~ref_bank;
      if (idx == 0) begin
         // quadrant flag only counts on the opening sample
         if (quad) begin
            ref_present = 1'b0;
         end
         head_value    = x;
         flat          = 1'b1;
         step_code_max = '0;
         ref_code_max  = '0;
      end else begin
         code = zigzag_of(x - prev_value);
         if (x != prev_value) begin
            flat = 1'b0;
         end
         if (code > step_code_max) begin
            step_code_max = code;
         end
      end
      if (ref_present) begin
         code = zigzag_of(history[int'(ref_bank) * SERIES_MAX + idx] - x);
         if (code > ref_code_max) begin
            ref_code_max = code;
         end
      end
      history[int'(fill_bank) * SERIES_MAX + idx] = x;
      prev_value = x;
      if (idx + 1 >= len) begin
         if (flat) begin
            r.kind  = KIND_FIXED;
            r.head  = head_value;
            r.width = '0;
         end else if (!ref_present) begin
            r.kind      = KIND_REF;
            r.head      = head_value;
            r.width     = bits_needed(step_code_max);
            ref_bank    = fill_bank;
            ref_present = 1'b1;
         end else begin
            r.kind  = KIND_CODED;
            r.head  = '0;
            r.width = bits_needed(ref_code_max);
         end
         series_results.insert(series_results.size(), r);
         pos = 0;
      end else begin
         pos = idx + 1;
      end
   endtask

   task check_result();
      series_result_type want;
      if (series_results.size() == 0) begin
         mismatches++;
         $display("%0t: response with no series outstanding: expected none, %s",
                  $time, "got");
         $display("%0t:    kind %0d head %h width %0d",
                  $time, rsp_series_kind, rsp_head_value, rsp_code_width);
      end else begin
         want = series_results.pop_front();
         if (rsp_series_kind !== want.kind) begin
            mismatches++;
            $display("%0t: series_kind expected %0d, got %0d", $time, want.kind, rsp_series_kind);
         end
         if (rsp_head_value !== want.head) begin
            mismatches++;
            $display("%0t: head_value expected %h, got %h", $time, want.head, rsp_head_value);
         end
         if (rsp_code_width !== want.width) begin
            mismatches++;
            $display("%0t: code_width expected %0d, got %0d", $time, want.width, rsp_code_width);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         length_reg    = LEN_RESET;
         ref_bank      = 1'b0;
         ref_present   = 1'b0;
         flat          = 1'b1;
         pos           = 0;
         prev_value    = '0;
         head_value    = '0;
         step_code_max = '0;
         ref_code_max  = '0;
         series_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            length_reg = csr_series_length;
         end
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (req_valid && req_ready) begin
            code_sample(req_sample, req_quadrant_start);
         end
      end
      pending_results <= series_results.size();
      fail_count      <= mismatches;
   end

endmodule

[test/reference_delta_zigzag_series_coder_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// reference_delta_zigzag_series_coder_test
// Drives samples, series length writes and response backpressure into the
// coder; a checker beside it predicts and compares every series result.
// ============================================================================

module reference_delta_zigzag_series_coder_test;
   import rdz_pkg::*;

   localparam int SERIES_MAX    = 1024;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 250;
   localparam int ITEM_COUNT    = 800;
   localparam int PROBE_SAMPLES = 32;

   typedef enum int {CONTENT_FLAT, CONTENT_SPIKE, CONTENT_WILD, CONTENT_NEAR} content_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_quadrant_start;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [1:0]                 rsp_series_kind;
   logic signed [SAMPLE_W-1:0] rsp_head_value;
   logic [CWIDTH_W-1:0]        rsp_code_width;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [LEN_W-1:0]           csr_series_length;

   int fail_count;
   int pending_results;
   int cycle_count  = 0;
   int hold_off_req = 0;   // bump to make the response side stall for a long stretch

   // sender's view of the series in progress
   logic [LEN_W-1:0]    cur_len;
   int                  sample_pos;
   int                  series_done;
   int                  items_sent;
   logic                force_quadrant;
   logic                tx_burst;
   content_type         content_mode;
   int                  noise_bits;
   int                  spike_pos;
   logic [SAMPLE_W-1:0] flat_value;
   logic [SAMPLE_W-1:0] pattern [SERIES_MAX];

   reference_delta_zigzag_series_coder #(
      .MAX_SERIES_LEN(SERIES_MAX)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_quadrant_start (req_quadrant_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_series_kind    (rsp_series_kind),
      .rsp_head_value     (rsp_head_value),
      .rsp_code_width     (rsp_code_width),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_series_length  (csr_series_length)
   );

   reference_delta_zigzag_series_coder_checker #(
      .SERIES_MAX(SERIES_MAX)
   ) coder_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_quadrant_start (req_quadrant_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_series_kind    (rsp_series_kind),
      .rsp_head_value     (rsp_head_value),
      .rsp_code_width     (rsp_code_width),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_series_length  (csr_series_length),
      .fail_count         (fail_count),
      .pending_results    (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int span(input logic [LEN_W-1:0] len);
      if (len == 0) begin
         return 1;
      end
      if (int'(len) > SERIES_MAX) begin
         return SERIES_MAX;
      end
      return int'(len);
   endfunction

   task new_pattern();
      int                  shape;
      logic [SAMPLE_W-1:0] base;
      logic [SAMPLE_W-1:0] step;
      shape = $urandom_range(0, 2);
      base  = $urandom();
      step  = (shape == 1) ? $urandom() : 32'($urandom_range(0, 8)) - 32'd4;
      for (int i = 0; i < SERIES_MAX; i++) begin
         pattern[i] = (shape == 0) ? $urandom() : base + step * i;
      end
   endtask

   task send_sample(input logic [SAMPLE_W-1:0] value, input logic flag);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_sample         <= value;
      req_quadrant_start <= flag;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
      if (sample_pos + 1 >= span(cur_len)) begin
         sample_pos = 0;
         series_done++;
      end else begin
         sample_pos++;
      end
   endtask

   task send_series_sample();
      int                  pick;
      logic                flag;
      logic [SAMPLE_W-1:0] value;
      logic [SAMPLE_W-1:0] mask;
      logic [SAMPLE_W-1:0] jitter;
      if (sample_pos == 0) begin
         flag = force_quadrant || ($urandom_range(0, 4) == 0);
         force_quadrant = 1'b0;
         if (flag) begin
            new_pattern();
         end
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            content_mode = CONTENT_FLAT;
         end else if (pick < 7) begin
            content_mode = CONTENT_SPIKE;
         end else if (pick < 10) begin
            content_mode = CONTENT_WILD;
         end else begin
            content_mode = CONTENT_NEAR;
         end
         noise_bits = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 32);
         flat_value = $urandom_range(0, 1) ? pattern[0] : $urandom();
         spike_pos  = $urandom_range(0, span(cur_len) - 1);
      end else begin
         // ignored off the series head
         flag = ($urandom_range(0, 3) == 0);
      end
      mask   = (noise_bits >= SAMPLE_W) ? '1 : (32'd1 << noise_bits) - 32'd1;
      jitter = $urandom() & mask;
      if ($urandom_range(0, 1)) begin
         jitter = -jitter;
      end
      case (content_mode)
         CONTENT_FLAT: begin
            value = flat_value;
         end
         CONTENT_SPIKE: begin
            value = (sample_pos == spike_pos) ? flat_value + 32'($urandom_range(1, 3))
                                              : flat_value;
         end
         CONTENT_WILD: begin
            value = $urandom();
         end
         default: begin
            value = pattern[sample_pos] + jitter;
         end
      endcase
      send_sample(value, flag);
   endtask

   // stop offering samples and let every result drain out
   task settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_length(input logic [LEN_W-1:0] len);
      settle();
      csr_valid         <= 1'b1;
      csr_series_length <= len;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      cur_len = len;
      // a longer series must not read reference entries never written
      force_quadrant = 1'b1;
   endtask

   initial begin : response_sink
      int   gap;
      int   holds_seen;
      logic rx_burst;
      holds_seen = 0;
      rx_burst   = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            rx_burst = !rx_burst;
         end
         gap = rx_burst ? 0 : $urandom_range(0, 7);
         if (hold_off_req != holds_seen) begin
            holds_seen = hold_off_req;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      int               first_series;
      int               target;
      int               pick;
      logic             first_phase;
      logic [LEN_W-1:0] len;
      req_valid          <= 1'b0;
      req_sample         <= '0;
      req_quadrant_start <= 1'b0;
      csr_valid          <= 1'b0;
      csr_series_length  <= '0;
      reset              <= 1'b1;
      cur_len        = LEN_RESET;
      sample_pos     = 0;
      series_done    = 0;
      items_sent     = 0;
      force_quadrant = 1'b1;
      tx_burst       = 1'b0;
      content_mode   = CONTENT_FLAT;
      noise_bits     = 0;
      spike_pos      = 0;
      flat_value     = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // the reset length keeps the series open; a short length closes it
      repeat (PROBE_SAMPLES) send_series_sample();
      write_length(11'd2);
      send_series_sample();

      // length 0 behaves as 1: every sample is its own fixed series
      write_length(11'd0);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h7fff_ffff, 1'b0);
      write_length(11'd1);
      send_sample(32'hffff_ffff, 1'b1);

      write_length(11'd4);
      send_sample(32'd5, 1'b1);
      send_sample(32'd5, 1'b0);
      send_sample(32'd5, 1'b0);
      send_sample(32'd5, 1'b0);
      // reference with the widest delta codes, then a series coded against it
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hffff_ffff, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h0000_0002, 1'b0);
      // constant while a reference exists
      send_sample(32'd9, 1'b0);
      send_sample(32'd9, 1'b0);
      send_sample(32'd9, 1'b0);
      send_sample(32'd9, 1'b0);
      // new quadrant drops the old reference
      send_sample(32'd1, 1'b1);
      send_sample(32'd2, 1'b0);
      send_sample(32'd3, 1'b0);
      send_sample(32'd5, 1'b0);
      // shrink the length with the series half done: it ends on the next sample
      send_sample(32'd10, 1'b0);
      send_sample(32'd12, 1'b0);
      write_length(11'd2);
      send_sample(32'd11, 1'b0);

      // response side stalls while samples keep coming, then a full drain
      write_length(11'd2);
      hold_off_req <= hold_off_req + 1;
      tx_burst = 1'b1;
      repeat (40) send_series_sample();
      settle();
      tx_burst = 1'b0;

      // above the maximum the length clamps; the series stays open until cut
      write_length(11'h7ff);
      repeat (PROBE_SAMPLES) send_series_sample();
      write_length(11'd3);
      send_series_sample();

      first_series = series_done;
      first_phase  = 1'b1;
      while (items_sent < ITEM_COUNT || series_done - first_series < 48) begin
         if (first_phase || $urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               len = 11'd0;
            end else if (pick == 1) begin
               len = 11'd1;
            end else if (pick == 2) begin
               len = 11'($urandom_range(13, 80));
            end else begin
               len = 11'($urandom_range(2, 12));
            end
            write_length(len);
            first_phase = 1'b0;
         end
         tx_burst = ($urandom_range(0, 3) == 0);
         target = series_done + ((span(cur_len) > 12) ? 2 : $urandom_range(2, 10));
         while (series_done < target) send_series_sample();
      end

      settle();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[files.f]
rtl/rdz_pkg.sv
rtl/rdz_ram.sv
rtl/rdz_front.sv
rtl/rdz_back.sv
rtl/reference_delta_zigzag_series_coder.sv
test/reference_delta_zigzag_series_coder_checker.sv
test/reference_delta_zigzag_series_coder_test.sv
